// ===== design/ccpi_pkg.sv =====
// shared types and constants for the cc/cv pi duty controller
// no dependencies; used by cc_cv_pi_duty_controller
`default_nettype none

package ccpi_pkg;

	// request kinds
	localparam logic [1:0] REQ_RESTART = 2'd0;
	localparam logic [1:0] REQ_TICK    = 2'd1;
	localparam logic [1:0] REQ_CHECK   = 2'd2;

	// configuration register indexes
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_TARGET   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CURRENT_TARGET   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CC_PROP_DIVISOR  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CC_INTEG_DIVISOR = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CV_PROP_DIVISOR  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CV_INTEG_DIVISOR = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SWITCH_LEVEL     = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_START_IN_CC      = 3'd7;

	// field widths
	localparam int ADC_W    = 12;
	localparam int VS_W     = 16;
	localparam int DIV_W    = 16;
	localparam int DUTY_W   = 9;
	localparam int ACC_W    = 24;
	localparam int FRAC_W   = 8;
	// raw error (target - sample) and clamped error, signed
	localparam int DIFF_W   = VS_W + 1;
	localparam int ERR_W    = ADC_W + 1;
	// dividend magnitudes: |err|*256 and |acc|*256
	localparam int P_W      = ERR_W - 1 + FRAC_W;
	localparam int DVD_W    = ACC_W + FRAC_W;
	localparam int CNT_W    = $clog2(DVD_W + 1);
	// q.8 duty sum: duty*256 + proportional + integral quotient
	localparam int SUM_W    = DVD_W + 2;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [VS_W-1:0]   voltage_sample;
		logic [ADC_W-1:0]  current_sample;
	} ccpi_req_t;

	typedef struct packed {
		logic [DUTY_W-1:0] duty_value;
		logic              cc_mode_now;
	} ccpi_rsp_t;

endpackage

`default_nettype wire

// ===== design/cc_cv_pi_duty_controller.sv =====
// Restart, mode check and unused kinds go from accept through the done state to the result register.
// A control tick runs a setup step, a 20-step proportional division,
// a 32-step integral division on the same shared restoring divider, one update, one output.
// Throughput: one item at a time; the next beat is taken once the result is registered.
// Reset (arst_n low): control and configuration registers to their reset values, duty DC_LOW, accumulator 0, cc mode.
// Depends on ccpi_pkg for payload types, register indexes and widths.
`default_nettype none

module cc_cv_pi_duty_controller #(
	parameter int ERR_HIGH         = 200,
	parameter int ERR_LOW          = -200,
	parameter int DC_HIGH          = 460,
	parameter int DC_LOW           = 25,
	parameter int TICKS_PER_PERIOD = 1024
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               req_valid,
	output logic                              req_stall,
	input  ccpi_pkg::ccpi_req_t               req_data,
	output logic                              rsp_valid,
	input  wire                               rsp_stall,
	output ccpi_pkg::ccpi_rsp_t               rsp_data,
	input  wire                               cfg_we,
	input  wire  [ccpi_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire  [ccpi_pkg::CFG_DATA_W-1:0]   cfg_data
);

	// integral divisor ki * TICKS_PER_PERIOD
	localparam int KID_W = ccpi_pkg::DIV_W + $clog2(TICKS_PER_PERIOD + 1);

	localparam int DIFF_W = ccpi_pkg::DIFF_W;
	localparam int ERR_W  = ccpi_pkg::ERR_W;
	localparam int ACC_W  = ccpi_pkg::ACC_W;
	localparam int DUTY_W = ccpi_pkg::DUTY_W;
	localparam int DVD_W  = ccpi_pkg::DVD_W;
	localparam int P_W    = ccpi_pkg::P_W;
	localparam int CNT_W  = ccpi_pkg::CNT_W;
	localparam int SUM_W  = ccpi_pkg::SUM_W;
	localparam int FRAC_W = ccpi_pkg::FRAC_W;

	localparam logic signed [DIFF_W-1:0] ERR_HI_D = DIFF_W'(ERR_HIGH);
	localparam logic signed [DIFF_W-1:0] ERR_LO_D = DIFF_W'(ERR_LOW);
	localparam logic signed [SUM_W-1:0]  DC_HI_Q  = SUM_W'(DC_HIGH * 256);
	localparam logic signed [SUM_W-1:0]  DC_LO_Q  = SUM_W'(DC_LOW * 256);
	localparam logic [DUTY_W-1:0]        DC_HI_D  = DUTY_W'(DC_HIGH);
	localparam logic [DUTY_W-1:0]        DC_LO_D  = DUTY_W'(DC_LOW);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PDIV = 3'd1;
	localparam logic [2:0] ST_IDIV = 3'd2;
	localparam logic [2:0] ST_UPD  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	// configuration
	logic [ccpi_pkg::ADC_W-1:0] voltage_target_q;
	logic [ccpi_pkg::ADC_W-1:0] current_target_q;
	logic [ccpi_pkg::DIV_W-1:0] cc_prop_q;
	logic [ccpi_pkg::DIV_W-1:0] cc_integ_q;
	logic [ccpi_pkg::DIV_W-1:0] cv_prop_q;
	logic [ccpi_pkg::DIV_W-1:0] cv_integ_q;
	logic [ccpi_pkg::VS_W-1:0]  switch_level_q;
	logic                       start_in_cc_q;

	// regulator state
	logic [DUTY_W-1:0]       duty_q;
	logic signed [ACC_W-1:0] acc_q;
	logic                    cc_mode_q;

	logic [2:0] state_q;
	logic       rsp_valid_q;
	ccpi_pkg::ccpi_rsp_t rsp_q;

	// shared divider
	logic [DVD_W-1:0]  dvd_q;
	logic [KID_W-1:0]  dvs_q;
	logic [KID_W-1:0]  rem_q;
	logic [DVD_W-1:0]  quo_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              neg_q;
	logic [KID_W-1:0]  kid_q;
	logic signed [P_W:0] qp_q;

	logic accept;
	logic rsp_free;

	logic signed [DIFF_W-1:0] diff;
	logic signed [ERR_W-1:0]  err;
	logic [ERR_W-2:0]         err_mag;
	logic signed [ACC_W-1:0]  acc_nx;
	logic [ACC_W-1:0]         acc_mag;
	logic [ccpi_pkg::DIV_W-1:0] kp_sel;
	logic [ccpi_pkg::DIV_W-1:0] ki_sel;
	logic [KID_W-1:0]         kid;

	logic [KID_W:0]   rem_sh;
	logic [KID_W+1:0] rem_diff;
	logic             qbit;
	logic [KID_W-1:0] rem_nx;
	logic [DVD_W-1:0] quo_nx;

	logic signed [P_W:0]   qp_nx;
	logic signed [DVD_W:0] qi;
	logic signed [SUM_W-1:0] sum;
	logic [DUTY_W-1:0]     duty_nx;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	// error, clamped; the difference is exact so a large voltage saturates low
	always_comb begin
		if (cc_mode_q) begin
			diff = $signed({5'd0, current_target_q}) - $signed({5'd0, req_data.current_sample});
		end else begin
			diff = $signed({5'd0, voltage_target_q}) - $signed({1'b0, req_data.voltage_sample});
		end
		if (diff > ERR_HI_D) begin
			err = ERR_W'(ERR_HI_D);
		end else if (diff < ERR_LO_D) begin
			err = ERR_W'(ERR_LO_D);
		end else begin
			err = diff[ERR_W-1:0];
		end
		err_mag = err[ERR_W-1] ? (ERR_W-1)'(-err) : err[ERR_W-2:0];
		acc_nx  = acc_q + ACC_W'(err);
		acc_mag = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : acc_q;
	end

	// gains of the present mode, zero acts as one
	always_comb begin
		kp_sel = cc_mode_q ? cc_prop_q : cv_prop_q;
		ki_sel = cc_mode_q ? cc_integ_q : cv_integ_q;
		if (kp_sel == '0) begin
			kp_sel = ccpi_pkg::DIV_W'(1);
		end
		if (ki_sel == '0) begin
			ki_sel = ccpi_pkg::DIV_W'(1);
		end
		kid = KID_W'(ki_sel) * KID_W'(TICKS_PER_PERIOD);
	end

	// one restoring step
	always_comb begin
		rem_sh   = {rem_q, dvd_q[DVD_W-1]};
		rem_diff = {1'b0, rem_sh} - {2'b00, dvs_q};
		qbit     = !rem_diff[KID_W+1];
		rem_nx   = qbit ? rem_diff[KID_W-1:0] : rem_sh[KID_W-1:0];
		quo_nx   = {quo_q[DVD_W-2:0], qbit};
		qp_nx    = neg_q ? -$signed({1'b0, quo_nx[P_W-1:0]}) : $signed({1'b0, quo_nx[P_W-1:0]});
	end

	// q.8 duty update with clamp
	always_comb begin
		qi  = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
		sum = $signed({{(SUM_W-DUTY_W-FRAC_W){1'b0}}, duty_q, {FRAC_W{1'b0}}})
			+ SUM_W'(qp_q) + SUM_W'(qi);
		if (sum >= DC_HI_Q) begin
			duty_nx = DC_HI_D;
		end else if (sum <= DC_LO_Q) begin
			duty_nx = DC_LO_D;
		end else begin
			duty_nx = sum[DUTY_W+FRAC_W-1:FRAC_W];
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			voltage_target_q <= '0;
			current_target_q <= '0;
			cc_prop_q        <= ccpi_pkg::DIV_W'(1);
			cc_integ_q       <= ccpi_pkg::DIV_W'(1);
			cv_prop_q        <= ccpi_pkg::DIV_W'(1);
			cv_integ_q       <= ccpi_pkg::DIV_W'(1);
			switch_level_q   <= '0;
			start_in_cc_q    <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ccpi_pkg::REG_VOLTAGE_TARGET:   voltage_target_q <= cfg_data[ccpi_pkg::ADC_W-1:0];
				ccpi_pkg::REG_CURRENT_TARGET:   current_target_q <= cfg_data[ccpi_pkg::ADC_W-1:0];
				ccpi_pkg::REG_CC_PROP_DIVISOR:  cc_prop_q        <= cfg_data;
				ccpi_pkg::REG_CC_INTEG_DIVISOR: cc_integ_q       <= cfg_data;
				ccpi_pkg::REG_CV_PROP_DIVISOR:  cv_prop_q        <= cfg_data;
				ccpi_pkg::REG_CV_INTEG_DIVISOR: cv_integ_q       <= cfg_data;
				ccpi_pkg::REG_SWITCH_LEVEL:     switch_level_q   <= cfg_data;
				ccpi_pkg::REG_START_IN_CC:      start_in_cc_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sequencer, regulator state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			duty_q      <= DC_LO_D;
			acc_q       <= '0;
			cc_mode_q   <= 1'b1;
			cnt_q       <= '0;
		end else begin
			if (state_q == ST_DONE && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (req_data.req_type)
							ccpi_pkg::REQ_RESTART: begin
								duty_q    <= DC_LO_D;
								acc_q     <= '0;
								cc_mode_q <= start_in_cc_q;
								state_q   <= ST_DONE;
							end
							ccpi_pkg::REQ_TICK: begin
								acc_q   <= acc_nx;
								cnt_q   <= CNT_W'(P_W);
								state_q <= ST_PDIV;
							end
							ccpi_pkg::REQ_CHECK: begin
								if (cc_mode_q && (req_data.voltage_sample > switch_level_q)) begin
									acc_q     <= '0;
									cc_mode_q <= 1'b0;
								end
								state_q <= ST_DONE;
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_PDIV: begin
					if (cnt_q == CNT_W'(1)) begin
						cnt_q   <= CNT_W'(DVD_W);
						state_q <= ST_IDIV;
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				ST_IDIV: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == CNT_W'(1)) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					duty_q  <= duty_nx;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (rsp_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers without reset
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && rsp_free) begin
			rsp_q.duty_value  <= duty_q;
			rsp_q.cc_mode_now <= cc_mode_q;
		end
		if (state_q == ST_IDLE && accept) begin
			// proportional dividend left-aligned so only its own width is stepped
			dvd_q <= {err_mag, {FRAC_W{1'b0}}, {(DVD_W-P_W){1'b0}}};
			dvs_q <= KID_W'(kp_sel);
			rem_q <= '0;
			quo_q <= '0;
			neg_q <= err[ERR_W-1];
			kid_q <= kid;
		end else if (state_q == ST_PDIV) begin
			if (cnt_q == CNT_W'(1)) begin
				qp_q  <= qp_nx;
				dvd_q <= {acc_mag, {FRAC_W{1'b0}}};
				dvs_q <= kid_q;
				rem_q <= '0;
				quo_q <= '0;
				neg_q <= acc_q[ACC_W-1];
			end else begin
				dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
				rem_q <= rem_nx;
				quo_q <= quo_nx;
			end
		end else if (state_q == ST_IDIV) begin
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			rem_q <= rem_nx;
			quo_q <= quo_nx;
		end
	end

	// a tick always starts the proportional division
	a_tick_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && accept && req_data.req_type == ccpi_pkg::REQ_TICK)
		|=> (state_q == ST_PDIV))
		else $error("tick did not start the divider");

	// partial remainder stays below the divisor while dividing
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PDIV || state_q == ST_IDIV) |-> (rem_q < dvs_q))
		else $error("divider remainder out of range");

	// cc mode only comes back through a restart
	a_cc_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(cc_mode_q) |-> $past(accept && req_data.req_type == ccpi_pkg::REQ_RESTART))
		else $error("cc mode set without restart");

	// a result beat is only produced from the done step
	a_rsp_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside done");

	// divider count never idles at zero while dividing
	a_cnt_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PDIV || state_q == ST_IDIV) |-> (cnt_q != '0))
		else $error("divider count ran out");

endmodule

`default_nettype wire
